// ----- src/rop_pkg.sv -----
// Shared types and constants for the Radon operator entry pipeline.
`default_nettype none

package rop_pkg;

    localparam int PHASE_BITS_DEF = 16;
    localparam int PIPE_STAGES    = 8;

    // Quarter turn in Q14 and the Q15 polynomial coefficients of the sine
    localparam logic [14:0] QUARTER = 15'd16384;
    localparam logic [15:0] COEF_A  = 16'd51472;
    localparam logic [15:0] COEF_B  = 16'd21024;
    localparam logic [15:0] COEF_C  = 16'd2320;
    localparam logic [15:0] SIN_MAX = 16'd32767;

    // Configuration register map
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_CURVE_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FREQUENCY  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PARAM_STEP = 2'd2;

    // Quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic [15:0] weight;
        logic [9:0]  trace_index;
        logic [9:0]  param_index;
    } side_t;

    typedef struct packed {
        logic [1:0]  quad;
        logic [14:0] t;
        logic [14:0] tc;
        logic [14:0] t2s;
        logic [14:0] t2c;
        side_t       side;
    } phase_t;

endpackage

`default_nettype wire

// ----- src/rop_horner_cell.sv -----
// One Horner cell of the quarter-sine polynomial: registered coef - (acc*x >> 14), or acc*x >> 14 if !SUBTRACT.
`default_nettype none

module rop_horner_cell #(
    parameter logic [15:0] COEF     = 16'd0,
    parameter bit          SUBTRACT = 1'b1
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [15:0] acc,
    input  wire logic [14:0] x,
    output logic [15:0]      result
);

    logic [30:0] prod;
    logic [15:0] scaled;
    logic [15:0] result_next;
    logic [15:0] result_reg;

    assign prod   = 31'(acc) * 31'(x);
    assign scaled = prod[29:14];

    always_comb
    begin
        if (SUBTRACT)
        begin
            result_next = COEF - scaled;
        end
        else
        begin
            result_next = scaled;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ----- src/rop_phase_unit.sv -----
// Phase product modulo 2^PHASE_BITS, quadrant split and squared arguments.
`default_nettype none

module rop_phase_unit #(
    parameter int PHASE_BITS = rop_pkg::PHASE_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [15:0] offset,
    input  wire logic signed [15:0] slowness,
    input  wire logic [15:0]        trace_weight,
    input  wire logic [9:0]         trace_index,
    input  wire logic [9:0]         param_index,
    input  wire logic               curve_mode,
    input  wire logic [15:0]        frequency,
    output rop_pkg::phase_t         phase
);
    import rop_pkg::*;

    localparam int PB = PHASE_BITS;

    // Only the low PB bits of the product matter, so every operand is cut to PB bits
    logic [23:0]     off_ext;
    logic [23:0]     slo_ext;
    logic [23:0]     freq_ext;
    logic [PB-1:0]   off_pb;
    logic [PB-1:0]   slo_pb;
    logic [PB-1:0]   freq_pb;
    logic [2*PB-1:0] prod1;
    logic [2*PB-1:0] prod2;
    logic [2*PB-1:0] prod3;
    logic [PB-1:0]   m2_next;
    logic [15:0]     p16;
    logic [14:0]     t;
    logic [14:0]     tc;
    logic [29:0]     sq_s;
    logic [29:0]     sq_c;
    phase_t          phase_next;

    logic [PB-1:0] m1_reg;
    logic [PB-1:0] off1_reg;
    side_t         side1_reg;
    logic [PB-1:0] m2_reg;
    side_t         side2_reg;
    logic [PB-1:0] m3_reg;
    side_t         side3_reg;
    phase_t        phase_reg;

    assign off_ext  = {{8{offset[15]}}, offset};
    assign slo_ext  = {{8{slowness[15]}}, slowness};
    assign freq_ext = {8'd0, frequency};
    assign off_pb   = off_ext[PB-1:0];
    assign slo_pb   = slo_ext[PB-1:0];
    assign freq_pb  = freq_ext[PB-1:0];

    assign prod1   = (2*PB)'(off_pb) * (2*PB)'(slo_pb);
    assign prod2   = (2*PB)'(m1_reg) * (2*PB)'(off1_reg);
    assign m2_next = curve_mode ? prod2[PB-1:0] : m1_reg;
    assign prod3   = (2*PB)'(m2_reg) * (2*PB)'(freq_pb);

    // Scale the wrapped phase to a 16-bit turn fraction
    generate
        if (PB >= 16)
        begin : g_trunc
            assign p16 = m3_reg[PB-1 -: 16];
        end
        else
        begin : g_widen
            assign p16 = {m3_reg, {(16-PB){1'b0}}};
        end
    endgenerate

    assign t    = {1'b0, p16[13:0]};
    assign tc   = QUARTER - t;
    assign sq_s = 30'(t) * 30'(t);
    assign sq_c = 30'(tc) * 30'(tc);

    always_comb
    begin
        phase_next.quad = p16[15:14];
        phase_next.t    = t;
        phase_next.tc   = tc;
        phase_next.t2s  = sq_s[28:14];
        phase_next.t2c  = sq_c[28:14];
        phase_next.side = side3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg                <= prod1[PB-1:0];
            off1_reg              <= off_pb;
            side1_reg.weight      <= trace_weight;
            side1_reg.trace_index <= trace_index;
            side1_reg.param_index <= param_index;
            m2_reg                <= m2_next;
            side2_reg             <= side1_reg;
            m3_reg                <= prod3[PB-1:0];
            side3_reg             <= side2_reg;
            phase_reg             <= phase_next;
        end
    end

    assign phase = phase_reg;

endmodule

`default_nettype wire

// ----- src/radon_operator_entry_unit.sv -----
// Top level: Radon operator entry pipeline with configuration registers.
// Throughput: one transaction per cycle while the output is not stalled; the eight-stage pipeline advances as one.
// A stalled output holds every stage; input ready follows the output side.
// Reset (rst_n low, asynchronous) clears the stage valids and sets curve_mode,
// frequency and param_step to zero.
`default_nettype none

module radon_operator_entry_unit #(
    parameter int PHASE_BITS = rop_pkg::PHASE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [rop_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rop_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [15:0]              offset,
    input  wire logic signed [15:0]              slowness,
    input  wire logic [15:0]                     trace_weight,
    input  wire logic [9:0]                      trace_index,
    input  wire logic [9:0]                      param_index,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [31:0]                   fwd_real,
    output logic signed [31:0]                   fwd_imag,
    output logic signed [31:0]                   adj_real,
    output logic signed [31:0]                   adj_imag,
    output logic [9:0]                           out_trace_index,
    output logic [9:0]                           out_param_index
);
    import rop_pkg::*;

    logic                   en;
    logic [PIPE_STAGES-1:0] valid_reg;
    logic                   curve_mode_reg;
    logic [15:0]            frequency_reg;
    logic [15:0]            param_step_reg;

    phase_t      phase;
    logic [14:0] t5_reg;
    logic [14:0] tc5_reg;
    logic [14:0] t2s5_reg;
    logic [14:0] t2c5_reg;
    logic [14:0] t6_reg;
    logic [14:0] tc6_reg;
    logic [1:0]  quad5_reg;
    logic [1:0]  quad6_reg;
    logic [1:0]  quad7_reg;
    side_t       side5_reg;
    side_t       side6_reg;
    side_t       side7_reg;

    logic [15:0] sin_r2;
    logic [15:0] sin_r4;
    logic [15:0] sin_r5;
    logic [15:0] cos_r2;
    logic [15:0] cos_r4;
    logic [15:0] cos_r5;

    logic [15:0]        s_t;
    logic [15:0]        s_c;
    logic signed [16:0] sn;
    logic signed [16:0] cs;
    logic signed [16:0] neg_sn;
    logic signed [16:0] stp_s;
    logic signed [16:0] wgt_s;
    logic signed [33:0] fwd_real_prod;
    logic signed [33:0] fwd_imag_prod;
    logic signed [33:0] adj_real_prod;
    logic signed [33:0] adj_imag_prod;

    logic signed [31:0] fwd_real_reg;
    logic signed [31:0] fwd_imag_reg;
    logic signed [31:0] adj_real_reg;
    logic signed [31:0] adj_imag_reg;
    logic [9:0]         trace_index_reg;
    logic [9:0]         param_index_reg;

    // Advance the whole pipeline unless a finished result is waiting
    assign en       = !valid_reg[PIPE_STAGES-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_mode_reg <= 1'b0;
            frequency_reg  <= '0;
            param_step_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CURVE_MODE: curve_mode_reg <= cfg_data[0];
                REG_FREQUENCY:  frequency_reg  <= cfg_data;
                REG_PARAM_STEP: param_step_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    rop_phase_unit #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .clk          (clk),
        .en           (en),
        .offset       (offset),
        .slowness     (slowness),
        .trace_weight (trace_weight),
        .trace_index  (trace_index),
        .param_index  (param_index),
        .curve_mode   (curve_mode_reg),
        .frequency    (frequency_reg),
        .phase        (phase)
    );

    // Sine lane: S(t)
    rop_horner_cell #(.COEF(COEF_B), .SUBTRACT(1'b1)) u_sin_c0 (
        .clk (clk), .en (en), .acc (COEF_C), .x (phase.t2s), .result (sin_r2)
    );
    rop_horner_cell #(.COEF(COEF_A), .SUBTRACT(1'b1)) u_sin_c1 (
        .clk (clk), .en (en), .acc (sin_r2), .x (t2s5_reg), .result (sin_r4)
    );
    rop_horner_cell #(.COEF(16'd0), .SUBTRACT(1'b0)) u_sin_c2 (
        .clk (clk), .en (en), .acc (sin_r4), .x (t6_reg), .result (sin_r5)
    );

    // Complement lane: S(quarter - t)
    rop_horner_cell #(.COEF(COEF_B), .SUBTRACT(1'b1)) u_cos_c0 (
        .clk (clk), .en (en), .acc (COEF_C), .x (phase.t2c), .result (cos_r2)
    );
    rop_horner_cell #(.COEF(COEF_A), .SUBTRACT(1'b1)) u_cos_c1 (
        .clk (clk), .en (en), .acc (cos_r2), .x (t2c5_reg), .result (cos_r4)
    );
    rop_horner_cell #(.COEF(16'd0), .SUBTRACT(1'b0)) u_cos_c2 (
        .clk (clk), .en (en), .acc (cos_r4), .x (tc6_reg), .result (cos_r5)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t5_reg    <= phase.t;
            tc5_reg   <= phase.tc;
            t2s5_reg  <= phase.t2s;
            t2c5_reg  <= phase.t2c;
            quad5_reg <= phase.quad;
            side5_reg <= phase.side;
            t6_reg    <= t5_reg;
            tc6_reg   <= tc5_reg;
            quad6_reg <= quad5_reg;
            side6_reg <= side5_reg;
            quad7_reg <= quad6_reg;
            side7_reg <= side6_reg;
        end
    end

    // Saturate, then fold the quadrant into signs
    assign s_t = (sin_r5 > SIN_MAX) ? SIN_MAX : sin_r5;
    assign s_c = (cos_r5 > SIN_MAX) ? SIN_MAX : cos_r5;

    always_comb
    begin
        case (quad7_reg)
            QUAD_0:
            begin
                sn = signed'({1'b0, s_t});
                cs = signed'({1'b0, s_c});
            end
            QUAD_1:
            begin
                sn = signed'({1'b0, s_c});
                cs = -signed'({1'b0, s_t});
            end
            QUAD_2:
            begin
                sn = -signed'({1'b0, s_t});
                cs = -signed'({1'b0, s_c});
            end
            default:
            begin
                sn = -signed'({1'b0, s_c});
                cs = signed'({1'b0, s_t});
            end
        endcase
    end

    assign neg_sn = -sn;
    assign stp_s  = signed'({1'b0, param_step_reg});
    assign wgt_s  = signed'({1'b0, side7_reg.weight});

    assign fwd_real_prod = 34'(stp_s) * 34'(cs);
    assign fwd_imag_prod = 34'(stp_s) * 34'(neg_sn);
    assign adj_real_prod = 34'(wgt_s) * 34'(cs);
    assign adj_imag_prod = 34'(wgt_s) * 34'(sn);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fwd_real_reg    <= fwd_real_prod[31:0];
            fwd_imag_reg    <= fwd_imag_prod[31:0];
            adj_real_reg    <= adj_real_prod[31:0];
            adj_imag_reg    <= adj_imag_prod[31:0];
            trace_index_reg <= side7_reg.trace_index;
            param_index_reg <= side7_reg.param_index;
        end
    end

    assign out_valid       = valid_reg[PIPE_STAGES-1];
    assign fwd_real        = fwd_real_reg;
    assign fwd_imag        = fwd_imag_reg;
    assign adj_real        = adj_real_reg;
    assign adj_imag        = adj_imag_reg;
    assign out_trace_index = trace_index_reg;
    assign out_param_index = param_index_reg;

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for the Radon operator entry unit: directed corners and random entries against a predictor.
`timescale 1ns / 100ps

module testbench;

    import rop_pkg::*;

    localparam int PHASE_W     = PHASE_BITS_DEF;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int BLOCK       = 100;

    typedef struct {
        logic signed [15:0] offset;
        logic signed [15:0] slowness;
        logic [15:0]        weight;
        logic [9:0]         trace_idx;
        logic [9:0]         param_idx;
    } entry_t;

    typedef struct {
        logic signed [31:0] fwd_re;
        logic signed [31:0] fwd_im;
        logic signed [31:0] adj_re;
        logic signed [31:0] adj_im;
        logic [9:0]         trace_idx;
        logic [9:0]         param_idx;
    } entry_pair_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic signed [15:0]     offset;
    logic signed [15:0]     slowness;
    logic [15:0]            trace_weight;
    logic [9:0]             trace_index;
    logic [9:0]             param_index;
    logic                   out_valid;
    logic                   out_ready;
    logic signed [31:0]     fwd_real;
    logic signed [31:0]     fwd_imag;
    logic signed [31:0]     adj_real;
    logic signed [31:0]     adj_imag;
    logic [9:0]             out_trace_index;
    logic [9:0]             out_param_index;

    // Copy of the configuration registers as the block should hold them
    logic        cur_curve_mode;
    logic [15:0] cur_frequency;
    logic [15:0] cur_param_step;

    entry_pair_t pending_pairs[$];

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int mismatch_count;
    int results_checked;
    int entries_sent;
    int settings_loaded;
    int idle_cycles;

    radon_operator_entry_unit #(
        .PHASE_BITS(PHASE_W)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .offset          (offset),
        .slowness        (slowness),
        .trace_weight    (trace_weight),
        .trace_index     (trace_index),
        .param_index     (param_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .fwd_real        (fwd_real),
        .fwd_imag        (fwd_imag),
        .adj_real        (adj_real),
        .adj_imag        (adj_imag),
        .out_trace_index (out_trace_index),
        .out_param_index (out_param_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Quarter-wave sine polynomial, Q14 angle in, Q15 magnitude out
    function automatic int poly_sine(input int unsigned t);
        int unsigned t2;
        int unsigned r;
        t2 = (t * t) >> 14;
        r = (COEF_C * t2) >> 14;
        r = COEF_B - r;
        r = (r * t2) >> 14;
        r = COEF_A - r;
        r = (r * t) >> 14;
        if (r > SIN_MAX)
            r = SIN_MAX;
        return int'(r);
    endfunction

    function automatic entry_pair_t predict_entry_pair(input entry_t e);
        logic [63:0] off_x;
        logic [63:0] slo_x;
        logic [63:0] prod;
        logic [15:0] p16;
        int unsigned tq;
        int s_t;
        int s_c;
        int sn;
        int cs;
        int stp;
        int wgt;
        entry_pair_t pair;
        off_x = {{48{e.offset[15]}}, e.offset};
        slo_x = {{48{e.slowness[15]}}, e.slowness};
        prod = off_x * slo_x;
        if (cur_curve_mode)
            prod = prod * off_x;
        prod = prod * {48'd0, cur_frequency};
        prod = prod & ((64'd1 << PHASE_W) - 64'd1);
        if (PHASE_W >= 16)
            p16 = 16'(prod >> (PHASE_W - 16));
        else
            p16 = 16'(prod << (16 - PHASE_W));
        tq = 32'(p16[13:0]);
        s_t = poly_sine(tq);
        s_c = poly_sine(32'(QUARTER) - tq);
        case (p16[15:14])
            QUAD_0:
            begin
                sn = s_t;
                cs = s_c;
            end
            QUAD_1:
            begin
                sn = s_c;
                cs = -s_t;
            end
            QUAD_2:
            begin
                sn = -s_t;
                cs = -s_c;
            end
            default:
            begin
                sn = -s_c;
                cs = s_t;
            end
        endcase
        stp = int'(cur_param_step);
        wgt = int'(e.weight);
        pair.fwd_re = stp * cs;
        pair.fwd_im = -(stp * sn);
        pair.adj_re = wgt * cs;
        pair.adj_im = wgt * sn;
        pair.trace_idx = e.trace_idx;
        pair.param_idx = e.param_idx;
        return pair;
    endfunction

    function automatic entry_t make_entry(input int off, input int slo, input int wgt,
                                          input int ti, input int pi);
        entry_t e;
        e.offset = 16'(off);
        e.slowness = 16'(slo);
        e.weight = 16'(wgt);
        e.trace_idx = 10'(ti);
        e.param_idx = 10'(pi);
        return e;
    endfunction

    function automatic entry_t random_entry();
        entry_t e;
        int v;
        // Small operands now and then keep the phase near the quadrant edges
        if ($urandom_range(3) == 0)
        begin
            v = $urandom_range(64);
            e.offset = 16'(v - 32);
            v = $urandom_range(64);
            e.slowness = 16'(v - 32);
        end
        else
        begin
            e.offset = 16'($urandom);
            e.slowness = 16'($urandom);
        end
        e.weight = 16'($urandom);
        e.trace_idx = 10'($urandom);
        e.param_idx = 10'($urandom);
        return e;
    endfunction

    task automatic report_failure(input string what, input logic signed [31:0] want_v,
                                  input logic signed [31:0] got_v);
        if (mismatch_count < 10)
            $display("Mismatch on %s at %0t: expected %0d, got %0d", what, $time, want_v, got_v);
        mismatch_count++;
    endtask

    task automatic send_entry(input entry_t e);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        offset <= e.offset;
        slowness <= e.slowness;
        trace_weight <= e.weight;
        trace_index <= e.trace_idx;
        param_index <= e.param_idx;
        do
            @(posedge clk);
        while (!in_ready);
        pending_pairs.push_back(predict_entry_pair(e));
        entries_sent++;
    endtask

    // Hold off new input until every outstanding result has been checked
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_settings(input logic mode, input logic [15:0] freq,
                                 input logic [15:0] step);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_CURVE_MODE;
        cfg_data <= {15'd0, mode};
        @(posedge clk);
        cfg_index <= REG_FREQUENCY;
        cfg_data <= freq;
        @(posedge clk);
        cfg_index <= REG_PARAM_STEP;
        cfg_data <= step;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_curve_mode = mode;
        cur_frequency = freq;
        cur_param_step = step;
        settings_loaded++;
    endtask

    // Registers at reset: zero frequency gives a zero phase, zero step a zero forward entry
    task automatic test_reset_values();
        send_entry(make_entry(1234, -77, 65535, 5, 6));
        send_entry(make_entry(-32768, 32767, 1, 1023, 0));
        send_entry(make_entry(17, 300, 40000, 0, 1023));
    endtask

    // Linear mode, unit frequency and offset: slowness is the phase itself
    task automatic test_quadrants();
        drain_pipeline();
        load_settings(1'b0, 16'd1, 16'hFFFF);
        send_entry(make_entry(1, 0, 65535, 0, 0));
        send_entry(make_entry(1, 8192, 65535, 1, 2));
        send_entry(make_entry(1, 16384, 65535, 2, 4));
        send_entry(make_entry(1, 24576, 0, 3, 8));
        send_entry(make_entry(1, -32768, 65535, 4, 16));
        send_entry(make_entry(1, -24576, 32768, 5, 32));
        send_entry(make_entry(1, -16384, 65535, 6, 64));
        send_entry(make_entry(1, -8192, 65535, 7, 128));
        send_entry(make_entry(1, 1, 65535, 512, 256));
        send_entry(make_entry(1, -1, 65535, 1023, 1023));
    endtask

    // Operand extremes in both moveout modes at full frequency and step
    task automatic test_field_extremes();
        entry_t corner[5];
        corner[0] = make_entry(-32768, -32768, 65535, 0, 1023);
        corner[1] = make_entry(32767, 32767, 0, 1023, 0);
        corner[2] = make_entry(-32768, 32767, 65535, 682, 341);
        corner[3] = make_entry(32767, -32768, 1, 341, 682);
        corner[4] = make_entry(-1, -1, 32768, 1023, 1023);
        for (int mode = 0; mode < 2; mode++)
        begin
            drain_pipeline();
            load_settings(mode[0], 16'hFFFF, 16'hFFFF);
            foreach (corner[k])
                send_entry(corner[k]);
        end
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int items);
        logic [15:0] freq;
        logic [15:0] step;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int b = 0; b < items / BLOCK; b++)
        begin
            case ($urandom_range(3))
                0: freq = 16'd0;
                1: freq = 16'hFFFF;
                2: freq = 16'($urandom);
                default: freq = 16'($urandom_range(1, 15));
            endcase
            case ($urandom_range(3))
                0: step = 16'd0;
                1: step = 16'hFFFF;
                default: step = 16'($urandom);
            endcase
            drain_pipeline();
            load_settings(1'($urandom_range(1)), freq, step);
            repeat (BLOCK)
                send_entry(random_entry());
        end
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        drain_pipeline();
        send_idle_pct = 0;
        hold_req = 1'b1;
        repeat (40)
            send_entry(random_entry());
    endtask

    // Sender waits for an empty pipeline between bursts
    task automatic test_drain_pause();
        for (int r = 0; r < 4; r++)
        begin
            repeat (8)
                send_entry(random_entry());
            drain_pipeline();
        end
    endtask

    initial
    begin : receiver
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_checker
        entry_pair_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pairs.size() == 0)
                report_failure("unexpected result, fwd_real", 0, fwd_real);
            else
            begin
                want = pending_pairs.pop_front();
                results_checked++;
                if (fwd_real !== want.fwd_re)
                    report_failure("fwd_real", want.fwd_re, fwd_real);
                if (fwd_imag !== want.fwd_im)
                    report_failure("fwd_imag", want.fwd_im, fwd_imag);
                if (adj_real !== want.adj_re)
                    report_failure("adj_real", want.adj_re, adj_real);
                if (adj_imag !== want.adj_im)
                    report_failure("adj_imag", want.adj_im, adj_imag);
                if (out_trace_index !== want.trace_idx)
                    report_failure("out_trace_index", 32'(want.trace_idx),
                                   32'(out_trace_index));
                if (out_param_index !== want.param_idx)
                    report_failure("out_param_index", 32'(want.param_idx),
                                   32'(out_param_index));
            end
        end
    end

    // Count cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout after %0d idle cycles, %0d results outstanding",
                     idle_cycles, pending_pairs.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        offset = '0;
        slowness = '0;
        trace_weight = '0;
        trace_index = '0;
        param_index = '0;
        cur_curve_mode = 1'b0;
        cur_frequency = '0;
        cur_param_step = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b0;
        mismatch_count = 0;
        results_checked = 0;
        entries_sent = 0;
        settings_loaded = 0;
        idle_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_quadrants();
        test_field_extremes();
        test_random_traffic(8, 54, 600);
        test_backpressure();
        test_random_traffic(54, 8, 600);
        test_drain_pause();
        test_random_traffic(0, 0, 600);

        drain_pipeline();
        repeat (2 * PIPE_STAGES) @(posedge clk);

        $display("Sent %0d entries over %0d register loads: both moveout modes, quadrant edges,",
                 entries_sent, settings_loaded);
        $display("operand and register extremes, long output stall and drained bursts; %0d checked.",
                 results_checked);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/rop_pkg.sv
src/rop_horner_cell.sv
src/rop_phase_unit.sv
src/radon_operator_entry_unit.sv
test/testbench.sv
